// File: rtl/wsam_pkg.sv
// wsam_pkg: shared types and constants for the windowed sigma anomaly monitor
// measurement and result payloads, register map, controller/datapath commands
// no dependencies
`timescale 1ns / 1ps

package wsam_pkg;

    typedef struct packed {
        logic               temp_present;
        logic signed [23:0] temp_value;
        logic               humid_present;
        logic signed [23:0] humid_value;
        logic               dust_present;
        logic signed [23:0] dust_value;
        logic               voc_present;
        logic signed [23:0] voc_value;
        logic               consumes_cycle;
    } meas_t;

    typedef struct packed {
        logic [3:0] anomaly_mask;
        logic       frequent_mode;
        logic [4:0] cycles_left;
        logic       schedule_frequent;
        logic       frequent_expired;
    } res_t;

    localparam int DELTA_W = 23;
    localparam int PCT_W   = 7;
    localparam int ADDR_W  = 5;

    localparam logic [2:0] REG_TEMP_MIN_DELTA  = 3'd0;
    localparam logic [2:0] REG_HUMID_MIN_DELTA = 3'd1;
    localparam logic [2:0] REG_DUST_MIN_DELTA  = 3'd2;
    localparam logic [2:0] REG_VOC_MIN_DELTA   = 3'd3;
    localparam logic [2:0] REG_TEMP_PERCENT    = 3'd4;
    localparam logic [2:0] REG_HUMID_PERCENT   = 3'd5;
    localparam logic [2:0] REG_DUST_PERCENT    = 3'd6;
    localparam logic [2:0] REG_VOC_PERCENT     = 3'd7;

    localparam logic [1:0] CH_HUMID = 2'd1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       latch;
        logic       chk;
        logic       rd;
        logic       t1;
        logic       t2;
        logic       t3;
        logic       t4;
        logic       wr;
        logic       fin;
        logic [1:0] chan;
    } cmd_t;

    typedef struct packed {
        logic present;
        logic full;
    } sts_t;

endpackage

// File: rtl/wsam_ctrl.sv
// wsam_ctrl: sequencer that walks the four channels of one request
// depends on wsam_pkg
`timescale 1ns / 1ps

module wsam_ctrl #(
    parameter int WINDOW = 10,
    parameter int IW     = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                meas_valid,
    output logic                meas_stall,
    output logic                res_valid,
    input  logic                res_stall,
    output wsam_pkg::cmd_t      cmd,
    output logic [IW-1:0]       idx,
    input  wsam_pkg::sts_t      sts
);
    import wsam_pkg::*;

    localparam int CW = $clog2(WINDOW + 2);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_ACC  = 4'd2;
    localparam logic [3:0] S_T1   = 4'd3;
    localparam logic [3:0] S_T2   = 4'd4;
    localparam logic [3:0] S_T3   = 4'd5;
    localparam logic [3:0] S_T4   = 4'd6;
    localparam logic [3:0] S_WR   = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [1:0]    chan_reg, chan_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        chan_next      = chan_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.chan       = chan_reg;
        if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (meas_valid)
                begin
                    cmd.latch  = 1'b1;
                    chan_next  = 2'd0;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                cmd.chk  = 1'b1;
                idx_next = '0;
                if (sts.present && sts.full)
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    state_next = S_WR;
                end
            end
            S_ACC:
            begin
                // reads go out first, then the state holds until the square/add pipe has drained
                cmd.rd   = (idx_reg < CW'(WINDOW));
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CW'(WINDOW + 1))
                begin
                    state_next = S_T1;
                end
            end
            S_T1:
            begin
                cmd.t1     = 1'b1;
                state_next = S_T2;
            end
            S_T2:
            begin
                cmd.t2     = 1'b1;
                state_next = S_T3;
            end
            S_T3:
            begin
                cmd.t3     = 1'b1;
                state_next = S_T4;
            end
            S_T4:
            begin
                cmd.t4     = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.wr = 1'b1;
                if (chan_reg == 2'd3)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    chan_next  = chan_reg + 1'b1;
                    state_next = S_CHK;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !res_stall)
                begin
                    cmd.fin        = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chan_reg      <= 2'd0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign meas_stall = (state_reg != S_IDLE);
    assign res_valid  = out_valid_reg;
    assign idx        = idx_reg[IW-1:0];

endmodule

// File: rtl/wsam_dp.sv
// wsam_dp: window memory, sum and square accumulators, threshold test, mode counter
// depends on wsam_pkg
`timescale 1ns / 1ps

module wsam_dp #(
    parameter int WINDOW          = 10,
    parameter int FREQUENT_CYCLES = 10,
    parameter int IW              = 4
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  wsam_pkg::cmd_t                          cmd,
    input  logic [IW-1:0]                           idx,
    output wsam_pkg::sts_t                          sts,
    input  wsam_pkg::meas_t                         meas,
    input  logic [3:0][wsam_pkg::DELTA_W-1:0]       min_delta,
    input  logic [3:0][wsam_pkg::PCT_W-1:0]         percent,
    output wsam_pkg::res_t                          res
);
    import wsam_pkg::*;

    localparam int FW  = $clog2(WINDOW + 1);
    localparam int SW  = 25 + IW;
    localparam int QW  = 48 + IW;
    localparam int NQW = QW + 5;
    localparam int DW  = SW + 6;
    localparam int MW  = QW + 7;
    localparam int XW  = 2 * DW + MW + 16;

    localparam logic signed [5:0] NS   = 6'(WINDOW);
    localparam logic signed [5:0] N1S  = 6'(WINDOW - 1);
    localparam logic signed [8:0] K9N  = 9'(9 * WINDOW);
    localparam logic signed [7:0] K100 = 8'sd100;
    localparam logic [4:0]        FC   = 5'(FREQUENT_CYCLES);

    logic signed [23:0] mem [4 * (2 ** IW)];

    meas_t                 meas_reg;
    logic [3:0][IW-1:0]    pos_reg;
    logic [3:0][FW-1:0]    fill_reg;
    logic                  mode_reg;
    logic [4:0]            cnt_reg;
    logic [3:0]            mask_reg;
    logic [FW-1:0]         maxrem_reg;
    logic                  test_reg;
    res_t                  res_reg;

    logic signed [23:0]    rdata_reg, sdat_reg;
    logic                  v1_reg, v2_reg;
    logic [47:0]           prod_reg;
    logic signed [SW-1:0]  s_reg;
    logic [QW-1:0]         q_reg;

    logic signed [DW-1:0]   nv_reg, d_reg;
    logic [NQW-1:0]         nq_reg;
    logic signed [2*SW-1:0] ss_reg;
    logic [27:0]            mdn_reg;
    logic [SW-1:0]          abs_s_reg;
    logic signed [MW-1:0]   m_reg;
    logic [SW+6:0]          pcts_reg;
    logic signed [DW+7:0]   d100_reg;
    logic signed [2*DW-1:0] dd_reg;
    logic signed [MW+8:0]   m9n_reg;
    logic signed [2*DW+5:0] ddn_reg;

    logic                   cur_present;
    logic signed [23:0]     cur_value;
    logic                   outlier;
    logic signed [DW-1:0]   s_ext;
    logic signed [MW-1:0]   m_diff;
    logic [FW-1:0]          fill_new;
    logic [FW-1:0]          rem;
    logic                   mode_a, mode_b;
    logic [4:0]             cnt_a, cnt_b;
    logic                   sched_a, sched_b, expired_b;

    always_comb
    begin
        unique case (cmd.chan)
            2'd0:
            begin
                cur_present = meas_reg.temp_present;
                cur_value   = meas_reg.temp_value;
            end
            2'd1:
            begin
                cur_present = meas_reg.humid_present;
                cur_value   = meas_reg.humid_value;
            end
            2'd2:
            begin
                cur_present = meas_reg.dust_present;
                cur_value   = meas_reg.dust_value;
            end
            default:
            begin
                cur_present = meas_reg.voc_present;
                cur_value   = meas_reg.voc_value;
            end
        endcase
    end

    assign sts.present = cur_present;
    assign sts.full    = (fill_reg[cmd.chan] == FW'(WINDOW));

    assign s_ext  = DW'(s_reg);
    assign m_diff = MW'(signed'({1'b0, nq_reg})) - MW'(ss_reg);

    // all four terms must clear their bound for an anomaly
    assign outlier = (d_reg > 0)
        && (XW'(d_reg) > XW'(signed'({1'b0, mdn_reg})))
        && (XW'(d100_reg) > XW'(signed'({1'b0, pcts_reg})))
        && (XW'(ddn_reg) > XW'(m9n_reg));

    assign fill_new = (fill_reg[cmd.chan] < FW'(WINDOW)) ? fill_reg[cmd.chan] + 1'b1
                                                         : fill_reg[cmd.chan];
    assign rem = FW'(WINDOW) - fill_new;

    // initial fill or anomaly first, then the consumed cycle
    always_comb
    begin
        mode_a  = mode_reg;
        cnt_a   = cnt_reg;
        sched_a = 1'b0;
        if (maxrem_reg != '0 && !mode_reg)
        begin
            mode_a  = 1'b1;
            cnt_a   = 5'(maxrem_reg);
            sched_a = 1'b1;
        end
        else if (mask_reg != 4'd0)
        begin
            mode_a  = 1'b1;
            cnt_a   = FC;
            sched_a = 1'b1;
        end
        mode_b    = mode_a;
        cnt_b     = cnt_a;
        sched_b   = sched_a;
        expired_b = 1'b0;
        if (meas_reg.consumes_cycle && mode_a)
        begin
            if (cnt_a != 5'd0)
            begin
                cnt_b = cnt_a - 1'b1;
            end
            if (cnt_b == 5'd0)
            begin
                mode_b    = 1'b0;
                expired_b = 1'b1;
                sched_b   = 1'b0;
            end
            else
            begin
                sched_b = 1'b1;
            end
        end
    end

    // window memory: one read or one write a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr && cur_present)
        begin
            mem[{cmd.chan, pos_reg[cmd.chan]}] <= cur_value;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[{cmd.chan, idx}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            meas_reg <= meas;
        end
        if (v1_reg)
        begin
            sdat_reg <= rdata_reg;
            prod_reg <= 48'($unsigned(48'(rdata_reg) * 48'(rdata_reg)));
        end
        if (cmd.chk)
        begin
            test_reg <= cur_present && sts.full;
            s_reg    <= '0;
            q_reg    <= '0;
        end
        else if (v2_reg)
        begin
            s_reg <= s_reg + SW'(sdat_reg);
            q_reg <= q_reg + QW'(prod_reg);
        end
        if (cmd.t1)
        begin
            nv_reg    <= DW'(cur_value) * DW'(NS);
            nq_reg    <= NQW'(q_reg) * NQW'(WINDOW);
            ss_reg    <= (2*SW)'(s_reg) * (2*SW)'(s_reg);
            mdn_reg   <= 28'(min_delta[cmd.chan]) * 28'(WINDOW);
            abs_s_reg <= (s_reg < 0) ? SW'(-s_reg) : SW'(s_reg);
        end
        if (cmd.t2)
        begin
            d_reg    <= (cmd.chan != CH_HUMID) ? nv_reg - s_ext : s_ext - nv_reg;
            m_reg    <= (m_diff < 0) ? '0 : m_diff;
            pcts_reg <= (SW+7)'(abs_s_reg) * (SW+7)'(percent[cmd.chan]);
        end
        if (cmd.t3)
        begin
            d100_reg <= (DW+8)'(d_reg) * (DW+8)'(K100);
            dd_reg   <= (2*DW)'(d_reg) * (2*DW)'(d_reg);
            m9n_reg  <= (MW+9)'(m_reg) * (MW+9)'(K9N);
        end
        if (cmd.t4)
        begin
            ddn_reg <= (2*DW+6)'(dd_reg) * (2*DW+6)'(N1S);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            pos_reg    <= '0;
            fill_reg   <= '0;
            mode_reg   <= 1'b0;
            cnt_reg    <= 5'd0;
            mask_reg   <= 4'd0;
            maxrem_reg <= '0;
            res_reg    <= '0;
        end
        else
        begin
            v1_reg <= cmd.rd;
            v2_reg <= v1_reg;
            if (cmd.latch)
            begin
                mask_reg   <= 4'd0;
                maxrem_reg <= '0;
            end
            if (cmd.wr && cur_present)
            begin
                if (test_reg && outlier)
                begin
                    mask_reg[cmd.chan] <= 1'b1;
                end
                pos_reg[cmd.chan] <= (pos_reg[cmd.chan] == IW'(WINDOW - 1)) ? '0
                                     : pos_reg[cmd.chan] + 1'b1;
                fill_reg[cmd.chan] <= fill_new;
                if (rem > maxrem_reg)
                begin
                    maxrem_reg <= rem;
                end
            end
            if (cmd.fin)
            begin
                mode_reg                  <= mode_b;
                cnt_reg                   <= cnt_b;
                res_reg.anomaly_mask      <= mask_reg;
                res_reg.frequent_mode     <= mode_b;
                res_reg.cycles_left       <= cnt_b;
                res_reg.schedule_frequent <= sched_b;
                res_reg.frequent_expired  <= expired_b;
            end
        end
    end

    assign res = res_reg;

endmodule

// File: rtl/windowed_sigma_anomaly_monitor_unit.sv
// each request walks all four channels; a present channel with a full window adds a pass over
// its window memory and the threshold steps T1 to T4 before its write
// throughput: one request at a time, set by the per-channel walk over the window memory
// a finished result waits in the output register while the next request is taken
// reset: windows empty, frequent mode off, registers at their default thresholds
`timescale 1ns / 1ps

module windowed_sigma_anomaly_monitor_unit #(
    parameter int WINDOW          = 10,
    parameter int FREQUENT_CYCLES = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          meas_valid,
    output logic                          meas_stall,
    input  wsam_pkg::meas_t               meas,
    output logic                          res_valid,
    input  logic                          res_stall,
    output wsam_pkg::res_t                res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsam_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import wsam_pkg::*;

    localparam int IW = $clog2(WINDOW);

    logic [3:0][DELTA_W-1:0] delta_reg;
    logic [3:0][PCT_W-1:0]   pct_reg;
    logic [2:0]              reg_idx;
    logic                    wr_en;
    cmd_t                    cmd;
    sts_t                    sts;
    logic [IW-1:0]           idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg[0] <= 23'd128;
            delta_reg[1] <= 23'd512;
            delta_reg[2] <= 23'd1280;
            delta_reg[3] <= 23'd1280;
            pct_reg[0]   <= 7'd10;
            pct_reg[1]   <= 7'd10;
            pct_reg[2]   <= 7'd15;
            pct_reg[3]   <= 7'd15;
        end
        else if (wr_en && paddr[1:0] == 2'd0)
        begin
            unique case (reg_idx)
                REG_TEMP_MIN_DELTA:  delta_reg[0] <= pwdata[DELTA_W-1:0];
                REG_HUMID_MIN_DELTA: delta_reg[1] <= pwdata[DELTA_W-1:0];
                REG_DUST_MIN_DELTA:  delta_reg[2] <= pwdata[DELTA_W-1:0];
                REG_VOC_MIN_DELTA:   delta_reg[3] <= pwdata[DELTA_W-1:0];
                REG_TEMP_PERCENT:    pct_reg[0]   <= pwdata[PCT_W-1:0];
                REG_HUMID_PERCENT:   pct_reg[1]   <= pwdata[PCT_W-1:0];
                REG_DUST_PERCENT:    pct_reg[2]   <= pwdata[PCT_W-1:0];
                REG_VOC_PERCENT:     pct_reg[3]   <= pwdata[PCT_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TEMP_MIN_DELTA:  prdata = 32'(delta_reg[0]);
            REG_HUMID_MIN_DELTA: prdata = 32'(delta_reg[1]);
            REG_DUST_MIN_DELTA:  prdata = 32'(delta_reg[2]);
            REG_VOC_MIN_DELTA:   prdata = 32'(delta_reg[3]);
            REG_TEMP_PERCENT:    prdata = 32'(pct_reg[0]);
            REG_HUMID_PERCENT:   prdata = 32'(pct_reg[1]);
            REG_DUST_PERCENT:    prdata = 32'(pct_reg[2]);
            REG_VOC_PERCENT:     prdata = 32'(pct_reg[3]);
            default:             prdata = 32'd0;
        endcase
    end

    wsam_ctrl #(
        .WINDOW (WINDOW),
        .IW     (IW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .meas_valid (meas_valid),
        .meas_stall (meas_stall),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .cmd        (cmd),
        .idx        (idx),
        .sts        (sts)
    );

    wsam_dp #(
        .WINDOW          (WINDOW),
        .FREQUENT_CYCLES (FREQUENT_CYCLES),
        .IW              (IW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .idx       (idx),
        .sts       (sts),
        .meas      (meas),
        .min_delta (delta_reg),
        .percent   (pct_reg),
        .res       (res)
    );

endmodule

// File: tb/sv/windowed_sigma_anomaly_monitor_unit_test.sv
// windowed_sigma_anomaly_monitor_unit_test: self-checking bench for the anomaly monitor
// predicts each report from its own copy of windows, counters and thresholds
// depends on wsam_pkg and windowed_sigma_anomaly_monitor_unit
`timescale 1ns / 1ps

module windowed_sigma_anomaly_monitor_unit_test;
    import wsam_pkg::*;

    localparam int WIN      = 10;
    localparam int FREQ_CYC = 10;
    localparam int SETTLE   = 120;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        meas_valid = 1'b0;
    logic        meas_stall;
    meas_t       meas = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_t        res;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    windowed_sigma_anomaly_monitor_unit #(.WINDOW(WIN), .FREQUENT_CYCLES(FREQ_CYC)) DUT (
        .clk(clk), .rst_n(rst_n),
        .meas_valid(meas_valid), .meas_stall(meas_stall), .meas(meas),
        .res_valid(res_valid), .res_stall(res_stall), .res(res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow of the block state
    longint          chan_win [4][WIN];
    int unsigned     wr_pos [4];
    int unsigned     fill_cnt [4];
    bit              freq_mode;
    int unsigned     cyc_left;
    int unsigned     min_delta [4];
    int unsigned     pct [4];

    meas_t  meas_backlog [$];
    res_t   expected_reports [$];
    int     errors = 0;
    int     reports_seen = 0;
    int     anomaly_reports = 0;
    int     expiries = 0;
    int     meas_sent = 0;

    int     burst_left = 0;
    int     gap_left = 0;
    int     hold_cycles = 0;
    int     stall_pct = 0;

    int     chan_base [4];
    int     chan_noise [4];

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic bit is_outlier(int c, longint v);
        longint s;
        longint q;
        longint d;
        longint abs_s;
        longint spread;
        longint unsigned lhs;
        longint unsigned rhs;
        s = 0;
        q = 0;
        for (int i = 0; i < WIN; i++)
        begin
            s += chan_win[c][i];
            q += chan_win[c][i] * chan_win[c][i];
        end
        d = (c != int'(CH_HUMID)) ? (WIN * v - s) : (s - WIN * v);
        if (d <= 0) return 1'b0;
        if (d <= WIN * longint'(min_delta[c])) return 1'b0;
        abs_s = (s < 0) ? -s : s;
        if (100 * d <= longint'(pct[c]) * abs_s) return 1'b0;
        spread = WIN * q - s * s;
        if (spread < 0) spread = 0;
        // squared k-sigma test, cross-multiplied
        lhs = longint'(d) * longint'(d) * (WIN - 1);
        rhs = 9 * WIN * spread;
        return lhs > rhs;
    endfunction

    function automatic res_t predict_report(meas_t m);
        logic [3:0]  mask;
        int unsigned max_rem;
        bit          sched;
        bit          expired;
        bit          pres;
        logic [23:0] raw;
        longint      v;
        res_t        r;
        mask = '0;
        max_rem = 0;
        sched = 1'b0;
        expired = 1'b0;
        for (int c = 0; c < 4; c++)
        begin
            case (c)
                0: begin pres = m.temp_present;  raw = m.temp_value;  end
                1: begin pres = m.humid_present; raw = m.humid_value; end
                2: begin pres = m.dust_present;  raw = m.dust_value;  end
                default: begin pres = m.voc_present; raw = m.voc_value; end
            endcase
            if (!pres) continue;
            v = longint'($signed(raw));
            if (fill_cnt[c] >= WIN && is_outlier(c, v)) mask[c] = 1'b1;
            chan_win[c][wr_pos[c]] = v;
            wr_pos[c] = (wr_pos[c] + 1) % WIN;
            if (fill_cnt[c] < WIN) fill_cnt[c]++;
            if (WIN - fill_cnt[c] > max_rem) max_rem = WIN - fill_cnt[c];
        end
        if (max_rem > 0 && !freq_mode)
        begin
            freq_mode = 1'b1;
            cyc_left = max_rem;
            sched = 1'b1;
        end
        else if (mask != 0)
        begin
            freq_mode = 1'b1;
            cyc_left = FREQ_CYC;
            sched = 1'b1;
        end
        if (m.consumes_cycle && freq_mode)
        begin
            if (cyc_left > 0) cyc_left--;
            if (cyc_left == 0)
            begin
                freq_mode = 1'b0;
                expired = 1'b1;
                sched = 1'b0;
            end
            else
                sched = 1'b1;
        end
        r.anomaly_mask = mask;
        r.frequent_mode = freq_mode;
        r.cycles_left = cyc_left[4:0];
        r.schedule_frequent = sched;
        r.frequent_expired = expired;
        return r;
    endfunction

    // sender: bursts of random length with random gaps
    always @(posedge clk)
    begin
        if (rst_n && (!meas_valid || !meas_stall))
        begin
            if (meas_valid)
            begin
                expected_reports = {expected_reports, predict_report(meas)};
                meas_sent++;
            end
            if (gap_left > 0)
            begin
                meas_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (meas_backlog.size() > 0)
            begin
                meas_valid <= 1'b1;
                meas <= meas_backlog.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                meas_valid <= 1'b0;
        end
    end

    // receiver: checks reports, stalls on its own pattern with two long hold-offs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: unexpected report %h", $time, res);
                    errors++;
                end
                else
                begin
                    res_t e;
                    e = expected_reports.pop_front();
                    if (res.anomaly_mask !== e.anomaly_mask)
                        $display("%0t: anomaly_mask expected %h actual %h", $time,
                                 e.anomaly_mask, res.anomaly_mask);
                    if (res.frequent_mode !== e.frequent_mode)
                        $display("%0t: frequent_mode expected %b actual %b", $time,
                                 e.frequent_mode, res.frequent_mode);
                    if (res.cycles_left !== e.cycles_left)
                        $display("%0t: cycles_left expected %0d actual %0d", $time,
                                 e.cycles_left, res.cycles_left);
                    if (res.schedule_frequent !== e.schedule_frequent)
                        $display("%0t: schedule_frequent expected %b actual %b", $time,
                                 e.schedule_frequent, res.schedule_frequent);
                    if (res.frequent_expired !== e.frequent_expired)
                        $display("%0t: frequent_expired expected %b actual %b", $time,
                                 e.frequent_expired, res.frequent_expired);
                    if (res !== e) errors++;
                    if (e.anomaly_mask != 0) anomaly_reports++;
                    if (e.frequent_expired) expiries++;
                end
                reports_seen++;
                if (reports_seen == 300 || reports_seen == 900) hold_cycles <= 600;
                if (reports_seen % 50 == 0)
                    case ($urandom_range(0, 2))
                        0: stall_pct <= 0;
                        1: stall_pct <= 30;
                        default: stall_pct <= 75;
                    endcase
            end
            if (hold_cycles > 0)
            begin
                res_stall <= 1'b1;
                hold_cycles <= hold_cycles - 1;
            end
            else
                res_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TEMP_MIN_DELTA:  min_delta[0] = val[22:0];
            REG_HUMID_MIN_DELTA: min_delta[1] = val[22:0];
            REG_DUST_MIN_DELTA:  min_delta[2] = val[22:0];
            REG_VOC_MIN_DELTA:   min_delta[3] = val[22:0];
            REG_TEMP_PERCENT:    pct[0] = val[6:0];
            REG_HUMID_PERCENT:   pct[1] = val[6:0];
            REG_DUST_PERCENT:    pct[2] = val[6:0];
            default:             pct[3] = val[6:0];
        endcase
    endtask

    task automatic drain();
        while (meas_backlog.size() > 0 || meas_valid || expected_reports.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_all(int unsigned d0, int unsigned d1, int unsigned d2, int unsigned d3,
                             int unsigned p0, int unsigned p1, int unsigned p2, int unsigned p3);
        reg_write(REG_TEMP_MIN_DELTA, d0);
        reg_write(REG_HUMID_MIN_DELTA, d1);
        reg_write(REG_DUST_MIN_DELTA, d2);
        reg_write(REG_VOC_MIN_DELTA, d3);
        reg_write(REG_TEMP_PERCENT, p0);
        reg_write(REG_HUMID_PERCENT, p1);
        reg_write(REG_DUST_PERCENT, p2);
        reg_write(REG_VOC_PERCENT, p3);
    endtask

    function automatic meas_t uniform_meas(int unsigned v);
        meas_t m;
        m.temp_present = 1'b1;  m.temp_value = v[23:0];
        m.humid_present = 1'b1; m.humid_value = v[23:0];
        m.dust_present = 1'b1;  m.dust_value = v[23:0];
        m.voc_present = 1'b1;   m.voc_value = v[23:0];
        m.consumes_cycle = 1'b1;
        return m;
    endfunction

    // sensor-like sample around a per-channel level, with occasional spikes and noise
    function automatic logic [23:0] sample(int c);
        int v;
        v = chan_base[c] + $signed($urandom_range(0, 2 * chan_noise[c])) - chan_noise[c];
        if ($urandom_range(0, 19) == 0)
            v = (c == 1) ? v - $urandom_range(0, 200000) : v + $urandom_range(0, 200000);
        if ($urandom_range(0, 39) == 0) v = $urandom;
        return v[23:0];
    endfunction

    task automatic queue_random(int count);
        meas_t m;
        for (int k = 0; k < count; k++)
        begin
            if (k % 60 == 0)
                for (int c = 0; c < 4; c++)
                begin
                    chan_base[c] = $signed($urandom_range(0, 2000000)) - 1000000;
                    chan_noise[c] = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 3000);
                end
            m.temp_present = ($urandom_range(0, 9) != 0);
            m.humid_present = ($urandom_range(0, 9) != 0);
            m.dust_present = ($urandom_range(0, 9) != 0);
            m.voc_present = ($urandom_range(0, 9) != 0);
            m.temp_value = sample(0);
            m.humid_value = sample(1);
            m.dust_value = sample(2);
            m.voc_value = sample(3);
            m.consumes_cycle = 1'($urandom_range(0, 1));
            meas_backlog = {meas_backlog, m};
        end
    endtask

    initial begin
        meas_t m;
        for (int c = 0; c < 4; c++)
        begin
            wr_pos[c] = 0;
            fill_cnt[c] = 0;
            for (int i = 0; i < WIN; i++) chan_win[c][i] = 0;
        end
        freq_mode = 1'b0;
        cyc_left = 0;
        min_delta = '{128, 512, 1280, 1280};
        pct = '{10, 10, 15, 15};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: partial fill with one channel absent, then extremes and spikes
        m = uniform_meas(24'h000100);
        m.voc_present = 1'b0;
        m.consumes_cycle = 1'b0;
        meas_backlog = {meas_backlog, m};
        for (int k = 0; k < 11; k++) meas_backlog = {meas_backlog, uniform_meas(24'h000A00)};
        meas_backlog = {meas_backlog, uniform_meas(24'h7FFFFF)};
        meas_backlog = {meas_backlog, uniform_meas(24'h800000)};
        for (int k = 0; k < 10; k++) meas_backlog = {meas_backlog, uniform_meas(24'h001000)};
        m = uniform_meas(24'h001000);
        m.temp_value = 24'h001081;
        m.dust_value = 24'h7FFFFF;
        m.voc_value = 24'h001000;
        m.humid_value = 24'h800000;
        m.consumes_cycle = 1'b0;
        meas_backlog = {meas_backlog, m};
        drain();

        // zero floors: only strict deviation and the sigma term matter
        write_all(0, 0, 0, 0, 0, 0, 0, 0);
        m = uniform_meas(24'h001000);
        meas_backlog = {meas_backlog, m};
        m.temp_value = 24'h001001;
        m.humid_value = 24'h000FFF;
        meas_backlog = {meas_backlog, m};
        queue_random(330);
        drain();

        // widest floors, with percent fields of 100 and full-scale 127
        write_all(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 100, 127, 100, 127);
        queue_random(320);
        drain();

        write_all($urandom_range(0, 4000), $urandom_range(0, 4000), $urandom_range(0, 4000),
                  $urandom_range(0, 4000), $urandom_range(0, 30), $urandom_range(0, 30),
                  $urandom_range(0, 100), $urandom_range(0, 127));
        queue_random(330);
        drain();

        write_all(128, 512, 1280, 1280, 10, 10, 15, 15);
        queue_random(330);
        drain();

        $display("covered %0d measurements, %0d reports with anomalies, %0d frequent-mode expiries",
                 meas_sent, anomaly_reports, expiries);
        $display("five threshold settings including zero and full-scale floors");
        if (errors == 0)
            $display("windowed_sigma_anomaly_monitor_unit_test: clean");
        else
            $display("windowed_sigma_anomaly_monitor_unit_test: errors");
        $finish;
    end

    initial begin
        #40ms;
        $display("timeout with %0d reports still expected", expected_reports.size());
        $display("windowed_sigma_anomaly_monitor_unit_test: errors");
        $finish;
    end

endmodule
